>>> hdl/srb_pkg.sv
// Shared types, operation and status codes, and defaults for the sequence reorder buffer.
package srb_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_SUBMIT    = 3'd1;
  localparam logic [2:0] OP_FETCH     = 3'd2;
  localparam logic [2:0] OP_ADVANCE   = 3'd3;
  localparam logic [2:0] OP_ADV_FETCH = 3'd4;
  localparam logic [2:0] OP_REWIND    = 3'd5;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_DROP = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] sequence_req;
    logic [15:0] buffer_tag;
  } in_item_t;

  typedef struct packed {
    logic        delivered;
    logic [15:0] delivered_tag;
    logic [31:0] expected_number;
    logic [1:0]  status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic adv;
    logic rd;
    logic exec;
    logic take;
    logic clr;
    logic rewind;
  } srb_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       need_take;
    logic       clr_last;
  } srb_stat_t;

endpackage

>>> hdl/srb_ctrl.sv
// Controller state machine that sequences each operation of the reorder buffer.
module srb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_strobe,
  output srb_pkg::srb_cmd_t cmd,
  input  srb_pkg::srb_stat_t stat
);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CALC = 4'd2;
  localparam logic [3:0] S_ADV  = 4'd3;
  localparam logic [3:0] S_READ = 4'd4;
  localparam logic [3:0] S_EXEC = 4'd5;
  localparam logic [3:0] S_TAKE = 4'd6;
  localparam logic [3:0] S_CLR  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    case (state_r)
      S_INIT: begin
        // Clearing pass after reset; no result is produced.
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        case (stat.op)
          srb_pkg::OP_ADD, srb_pkg::OP_SUBMIT, srb_pkg::OP_FETCH: begin
            state_nxt = S_READ;
          end
          srb_pkg::OP_ADVANCE, srb_pkg::OP_ADV_FETCH: begin
            state_nxt = S_ADV;
          end
          srb_pkg::OP_REWIND: begin
            cmd.rewind = 1'b1;
            state_nxt  = S_CLR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ADV: begin
        cmd.adv = 1'b1;
        if (stat.op == srb_pkg::OP_ADV_FETCH) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_take) begin
          state_nxt = S_TAKE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_strobe = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

>>> hdl/srb_dp.sv
// Datapath of the reorder buffer: slot memory, expected number and result registers.
module srb_dp #(
  parameter int DEPTH    = srb_pkg::DEPTH_DEF,
  parameter int TAG_BITS = srb_pkg::TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srb_pkg::in_item_t  in_data,
  input  srb_pkg::srb_cmd_t  cmd,
  output srb_pkg::srb_stat_t stat,
  output srb_pkg::out_item_t out_data
);

  localparam int SLOT_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STORE_BITS = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int WORD_W     = STORE_BITS + 1;

  // Each word holds a valid bit above the stored tag.
  logic [WORD_W-1:0] mem [DEPTH];

  logic [2:0]            op_r;
  logic [31:0]           seq_r;
  logic [STORE_BITS-1:0] tag_r;
  logic [31:0]           diff_r;
  logic                  match_r;
  logic                  wrapped_r;
  logic [31:0]           exp_r;
  logic [SLOT_W-1:0]     exp_slot_r;
  logic [SLOT_W-1:0]     clr_idx_r;
  logic [WORD_W-1:0]     park_rd_r;
  logic [WORD_W-1:0]     exp_rd_r;
  logic                  res_dlv_r;
  logic [STORE_BITS-1:0] res_tag_r;
  logic [1:0]            res_status_r;

  logic [SLOT_W:0]       slot_sum;
  logic [SLOT_W-1:0]     park_slot;
  logic                  in_win;
  logic                  park_v;
  logic                  exp_v;
  logic                  park_op;
  logic                  take_op;
  logic                  parking;
  logic                  same;
  logic [1:0]            exec_status;
  logic                  exec_dlv;
  logic [STORE_BITS-1:0] exec_tag;
  logic                  wr_en;
  logic [SLOT_W-1:0]     wr_addr;
  logic [WORD_W-1:0]     wr_word;
  logic [SLOT_W-1:0]     exp_slot_inc;

  // Inside the window a wrapped number is below DEPTH, so it is its own slot;
  // otherwise the slot is the expected slot plus the offset, folded once.
  always_comb begin
    in_win   = (diff_r < 32'(DEPTH));
    slot_sum = {1'b0, exp_slot_r} + {1'b0, diff_r[SLOT_W-1:0]};
    if (wrapped_r) begin
      park_slot = seq_r[SLOT_W-1:0];
    end else if (slot_sum >= (SLOT_W+1)'(DEPTH)) begin
      park_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(DEPTH));
    end else begin
      park_slot = slot_sum[SLOT_W-1:0];
    end
  end

  always_comb begin
    park_v  = park_rd_r[WORD_W-1];
    exp_v   = exp_rd_r[WORD_W-1];
    park_op = (op_r == srb_pkg::OP_ADD) || ((op_r == srb_pkg::OP_SUBMIT) && !match_r);
    take_op = ((op_r == srb_pkg::OP_SUBMIT) && !match_r) || (op_r == srb_pkg::OP_FETCH) ||
              (op_r == srb_pkg::OP_ADV_FETCH);
    parking = park_op && in_win && !park_v;
    // A wrapped item can land in the expected slot; it is then released at once.
    same    = parking && take_op && (park_slot == exp_slot_r);

    if (!park_op) begin
      exec_status = srb_pkg::STAT_OK;
    end else if (!in_win) begin
      exec_status = srb_pkg::STAT_DROP;
    end else if (park_v) begin
      exec_status = srb_pkg::STAT_DUP;
    end else begin
      exec_status = srb_pkg::STAT_OK;
    end

    exec_dlv = 1'b0;
    exec_tag = '0;
    if ((op_r == srb_pkg::OP_SUBMIT) && match_r) begin
      exec_dlv = 1'b1;
      exec_tag = tag_r;
    end else if (same) begin
      exec_dlv = 1'b1;
      exec_tag = tag_r;
    end else if (take_op && exp_v) begin
      exec_dlv = 1'b1;
      exec_tag = exp_rd_r[STORE_BITS-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = exp_slot_r;
    wr_word = '0;
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
    end else if (cmd.adv || cmd.take) begin
      wr_en = 1'b1;
    end else if (cmd.exec && parking && !same) begin
      wr_en   = 1'b1;
      wr_addr = park_slot;
      wr_word = {1'b1, tag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (cmd.rd) begin
      park_rd_r <= mem[park_slot];
      exp_rd_r  <= mem[exp_slot_r];
    end
  end

  always_comb begin
    if (exp_r == 32'hFFFF_FFFF) begin
      exp_slot_inc = '0;
    end else if (exp_slot_r == SLOT_W'(DEPTH - 1)) begin
      exp_slot_inc = '0;
    end else begin
      exp_slot_inc = exp_slot_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r      <= '0;
      exp_slot_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      if (cmd.rewind) begin
        exp_r      <= '0;
        exp_slot_r <= '0;
      end else if (cmd.adv) begin
        exp_r      <= exp_r + 32'd1;
        exp_slot_r <= exp_slot_inc;
      end
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + SLOT_W'(1);
      end else begin
        clr_idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_data.operation;
      seq_r        <= in_data.sequence_req;
      tag_r        <= in_data.buffer_tag[STORE_BITS-1:0];
      res_dlv_r    <= 1'b0;
      res_tag_r    <= '0;
      res_status_r <= srb_pkg::STAT_OK;
    end
    if (cmd.calc) begin
      diff_r    <= seq_r - exp_r;
      match_r   <= (seq_r == exp_r);
      wrapped_r <= (seq_r < exp_r);
    end
    if (cmd.exec) begin
      res_dlv_r    <= exec_dlv;
      res_tag_r    <= exec_tag;
      res_status_r <= exec_status;
    end
  end

  always_comb begin
    stat.op        = op_r;
    stat.need_take = take_op && !same && exp_v;
    stat.clr_last  = (clr_idx_r == SLOT_W'(DEPTH - 1));
  end

  always_comb begin
    out_data.delivered       = res_dlv_r;
    out_data.delivered_tag   = 16'(res_tag_r);
    out_data.expected_number = exp_r;
    out_data.status          = res_status_r;
  end

endmodule

>>> hdl/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: controller plus datapath.
//
//  channel   ports                      handshake
//  --------  -------------------------  --------------------------------------
//  input     start, busy, in_data       taken at an edge with start high, busy low
//  result    out_strobe, out_data       one cycle per result, cannot be held off
//
// One transaction is in flight at a time. After the accepting edge busy stays high
// through the calculate, read and execute states for an add, submit or fetch, the
// advance state for an advance, all of these for an advance_and_fetch and the
// clearing sweep for a rewind; an extra take state clears a released slot, as the
// slot memory has a single write port. The result strobe marks the last busy cycle.
// After reset a clearing pass over all DEPTH slots runs with busy high.
module sequence_reorder_buffer #(
  parameter int DEPTH    = srb_pkg::DEPTH_DEF,
  parameter int TAG_BITS = srb_pkg::TAG_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  srb_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output srb_pkg::out_item_t out_data
);

  srb_pkg::srb_cmd_t  cmd;
  srb_pkg::srb_stat_t stat;

  srb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .stat       (stat)
  );

  srb_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

>>> tb/tb.sv
// Testbench for the sequence reorder buffer: queued command driver, result monitor and predictor.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = srb_pkg::DEPTH_DEF;

  // Operation codes that the block leaves unused.
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  typedef struct {
    srb_pkg::in_item_t item;
    int unsigned       gap;
    bit                drain;
  } tx_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  srb_pkg::in_item_t  in_data = '0;
  logic               busy;
  logic               out_strobe;
  srb_pkg::out_item_t out_data;

  // Commands still to be driven and results still owed by the block.
  tx_t                tx_q[$];
  srb_pkg::out_item_t due_results[$];

  int          n_sent = 0;
  int          n_recv = 0;
  int          n_errors = 0;
  int unsigned idle_left = 0;
  bit          gap_armed = 1'b0;
  logic [31:0] gen_seq = '0;

  // Predictor state.
  logic [31:0] next_seq = '0;
  bit          slot_held[DEPTH];
  logic [15:0] slot_tag[DEPTH];

  sequence_reorder_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [1:0] park_item(logic [31:0] seq, logic [15:0] tag);
    logic [31:0] span;
    int unsigned idx;
    span = seq - next_seq;
    idx = seq % DEPTH;
    if (span >= 32'(DEPTH)) return srb_pkg::STAT_DROP;
    if (slot_held[idx]) return srb_pkg::STAT_DUP;
    slot_held[idx] = 1'b1;
    slot_tag[idx] = tag;
    return srb_pkg::STAT_OK;
  endfunction

  function automatic bit take_head(output logic [15:0] tag);
    int unsigned idx;
    idx = next_seq % DEPTH;
    tag = '0;
    if (!slot_held[idx]) return 1'b0;
    tag = slot_tag[idx];
    slot_held[idx] = 1'b0;
    return 1'b1;
  endfunction

  // Moving past a number drops whatever was parked for it.
  function automatic void skip_head();
    slot_held[next_seq % DEPTH] = 1'b0;
    next_seq = next_seq + 32'd1;
  endfunction

  function automatic srb_pkg::out_item_t reorder_step(srb_pkg::in_item_t it);
    srb_pkg::out_item_t r;
    logic [1:0]         st;
    bit                 got;
    logic [15:0]        gtag;
    st = srb_pkg::STAT_OK;
    got = 1'b0;
    gtag = '0;
    case (it.operation)
      srb_pkg::OP_ADD: begin
        st = park_item(it.sequence_req, it.buffer_tag);
      end
      srb_pkg::OP_SUBMIT: begin
        if (it.sequence_req == next_seq) begin
          got = 1'b1;
          gtag = it.buffer_tag;
        end else begin
          st = park_item(it.sequence_req, it.buffer_tag);
          got = take_head(gtag);
        end
      end
      srb_pkg::OP_FETCH: begin
        got = take_head(gtag);
      end
      srb_pkg::OP_ADVANCE: begin
        skip_head();
      end
      srb_pkg::OP_ADV_FETCH: begin
        skip_head();
        got = take_head(gtag);
      end
      srb_pkg::OP_REWIND: begin
        next_seq = '0;
        foreach (slot_held[i]) slot_held[i] = 1'b0;
      end
      default: ;
    endcase
    r.delivered = got;
    r.delivered_tag = got ? gtag : 16'd0;
    r.expected_number = next_seq;
    r.status = st;
    return r;
  endfunction

  function automatic void queue_tx(logic [2:0] op, logic [31:0] seq, logic [15:0] tag,
                                   int unsigned gap, bit drain);
    tx_t t;
    t.item.operation = op;
    t.item.sequence_req = seq;
    t.item.buffer_tag = tag;
    t.gap = gap;
    t.drain = drain;
    tx_q.push_back(t);
    // Track the expected number so that random numbers can aim at the window.
    if (op == srb_pkg::OP_ADVANCE || op == srb_pkg::OP_ADV_FETCH) gen_seq = gen_seq + 32'd1;
    else if (op == srb_pkg::OP_REWIND) gen_seq = '0;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Driver: one command at a time, each preceded by its own idle gap.
  always @(posedge clk) begin
    tx_t nxt;
    bit  took;
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_armed = 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        due_results.push_back(reorder_step(in_data));
        n_sent <= n_sent + 1;
      end
      if (start && !took) begin
        // The command stays on the port until the block takes it.
      end else if (tx_q.size() == 0) begin
        start <= 1'b0;
      end else if (tx_q[0].drain && (n_sent + took) != n_recv) begin
        start <= 1'b0;
      end else begin
        if (!gap_armed) begin
          idle_left = tx_q[0].gap;
          gap_armed = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else begin
          nxt = tx_q.pop_front();
          gap_armed = 1'b0;
          in_data <= nxt.item;
          start <= 1'b1;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    srb_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      n_recv <= n_recv + 1;
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = due_results.pop_front();
        check_field("delivered", 32'(want.delivered), 32'(out_data.delivered));
        check_field("delivered_tag", 32'(want.delivered_tag), 32'(out_data.delivered_tag));
        check_field("expected_number", want.expected_number, out_data.expected_number);
        check_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  initial begin
    int          pick;
    int unsigned gap;
    bit          drain;
    logic [31:0] seq;
    logic [2:0]  op;

    // Directed part: window edges, duplicates, drops, pass-through, skipped item,
    // rewind flush and the unused operation codes.
    queue_tx(srb_pkg::OP_ADD, 32'd0, 16'hFFFF, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd0, 16'h1234, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd15, 16'h0000, 1, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd16, 16'hAAAA, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'hFFFF_FFFF, 16'h5555, 2, 1'b0);
    queue_tx(srb_pkg::OP_SUBMIT, 32'd0, 16'h0F0F, 0, 1'b0);
    queue_tx(srb_pkg::OP_FETCH, 32'd0, 16'h0000, 0, 1'b0);
    queue_tx(srb_pkg::OP_FETCH, 32'hFFFF_FFFF, 16'hFFFF, 3, 1'b0);
    queue_tx(srb_pkg::OP_SUBMIT, 32'hAAAA_AAAA, 16'hFFFF, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd1, 16'hBEEF, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADVANCE, 32'd0, 16'h0000, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADV_FETCH, 32'd0, 16'h0000, 1, 1'b0);
    queue_tx(srb_pkg::OP_SUBMIT, 32'd3, 16'hC0DE, 0, 1'b0);
    queue_tx(srb_pkg::OP_SUBMIT, 32'd2, 16'h7777, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADVANCE, 32'h5555_5555, 16'hAAAA, 0, 1'b0);
    queue_tx(srb_pkg::OP_FETCH, 32'd0, 16'h0000, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd17, 16'h1111, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd18, 16'h2222, 0, 1'b0);
    queue_tx(srb_pkg::OP_ADD, 32'd19, 16'h3333, 0, 1'b0);
    queue_tx(OP_UNUSED_A, 32'd18, 16'hFFFF, 0, 1'b0);
    queue_tx(OP_UNUSED_B, 32'hFFFF_FFFF, 16'hFFFF, 0, 1'b0);
    queue_tx(srb_pkg::OP_REWIND, 32'd0, 16'h0000, 0, 1'b1);
    queue_tx(srb_pkg::OP_FETCH, 32'd0, 16'h0000, 0, 1'b0);
    queue_tx(srb_pkg::OP_SUBMIT, 32'd5, 16'h8001, 4, 1'b0);
    queue_tx(srb_pkg::OP_ADV_FETCH, 32'd0, 16'h0000, 0, 1'b0);

    // Random part: mostly numbers inside the current window, some noise.
    // Blocks alternate between random gaps and back-to-back commands.
    for (int blk = 0; blk < 30; blk++) begin
      for (int k = 0; k < 60; k++) begin
        pick = $urandom_range(0, 99);
        gap = (blk % 2 == 0) ? $urandom_range(0, 14) : 0;
        drain = (k == 0) && (blk % 5 == 4);
        seq = gen_seq + $urandom_range(0, DEPTH - 1);
        op = srb_pkg::OP_FETCH;
        if (pick < 30) begin
          op = srb_pkg::OP_ADD;
        end else if (pick < 50) begin
          op = srb_pkg::OP_SUBMIT;
          if ($urandom_range(0, 3) == 0) seq = gen_seq;
        end else if (pick < 60) begin
          op = srb_pkg::OP_FETCH;
        end else if (pick < 68) begin
          op = srb_pkg::OP_ADVANCE;
        end else if (pick < 82) begin
          op = srb_pkg::OP_ADV_FETCH;
        end else if (pick < 85) begin
          op = srb_pkg::OP_REWIND;
        end else begin
          op = $urandom_range(0, 1) ? srb_pkg::OP_SUBMIT : srb_pkg::OP_ADD;
          case ($urandom_range(0, 2))
            0: seq = $urandom();
            1: seq = gen_seq + DEPTH + $urandom_range(0, 3);
            default: seq = gen_seq - $urandom_range(1, 4);
          endcase
        end
        queue_tx(op, seq, 16'($urandom_range(0, 65535)), gap, drain);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (!(tx_q.size() == 0 && !start && n_sent == n_recv)) @(negedge clk);
    repeat (2 * DEPTH + 10) @(negedge clk);

    if (due_results.size() != 0) begin
      n_errors++;
      $display("%0t ns: results missing, expected %0d more, actual none", $time,
               due_results.size());
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hdl/srb_pkg.sv
hdl/srb_ctrl.sv
hdl/srb_dp.sv
hdl/sequence_reorder_buffer.sv
tb/tb.sv
